FILE: design/double_ended_queue_core_defines.svh
// assertion macros for the double ended queue core
// included by double_ended_queue_core.sv, no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, checked outside reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

FILE: design/dq_pkg.sv
// types, codes and ring index helper for the double ended queue core
// no dependencies
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SIZE       = 3'd4,
    REQ_EMPTY      = 3'd5,
    REQ_PEEK_FRONT = 3'd6,
    REQ_PEEK_BACK  = 3'd7
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } dq_out_t;

  // base + off, wrapped into the ring
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

FILE: design/double_ended_queue_core.sv
// double ended queue core: ring buffer in one synchronous memory
// depends on dq_pkg and double_ended_queue_core_defines.svh
//
//   port group   dir   handshake              word
//   in_*         in    in_valid / in_ready    dq_pkg::dq_in_t
//   out_*        out   out_valid / out_ready  dq_pkg::dq_out_t
//
// one word per cycle while the output is not stalled; results pass the middle
// stage, then the output register. pointers and count update at accept,
// the memory is read or written in that cycle and its read data is muxed in next.
// reset clears head, count and the pipeline valids; memory contents are not cleared.
// a stalled output holds the middle stage, which then holds in_ready low.
`timescale 1ns / 1ps
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  logic [31:0]   mem_r [DEPTH];
  logic [31:0]   rd_q_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // middle stage: result pending on memory read data or fixed value
  logic          s1_v_r;
  logic          s1_mem_r;
  logic [31:0]   s1_rv_r;
  logic [1:0]    s1_st_r;

  logic          out_v_r;
  dq_out_t       out_data_r;

  logic          in_fire, s1_adv;
  logic          full, empty;
  logic [AW-1:0] cnt_lo, back_idx, last_idx, front_m1;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          res_mem;
  logic [31:0]   res_rv;
  logic [1:0]    res_st;
  logic          push_ok;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign cnt_lo   = count_r[AW-1:0];
  assign back_idx = ring_add(head_r, cnt_lo);
  assign last_idx = ring_add(head_r, cnt_lo - AW'(1));
  assign front_m1 = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    res_mem   = 1'b0;
    res_rv    = '0;
    res_st    = ST_OK;
    push_ok   = 1'b0;
    if (in_fire) begin
      case (in_data.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            res_st = ST_FULL;
          end else begin
            push_ok   = 1'b1;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (in_data.req_type == REQ_PUSH_FRONT) begin
              head_nxt = front_m1;
              wr_addr  = front_m1;
            end else begin
              wr_addr = back_idx;
            end
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (empty) begin
            res_rv = '1;
            res_st = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_r;
            res_mem = 1'b1;
            if (in_data.req_type == REQ_POP_FRONT) begin
              head_nxt  = ring_add(head_r, AW'(1));
              count_nxt = count_r - CW'(1);
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (empty) begin
            res_rv = '1;
            res_st = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
            res_mem = 1'b1;
            if (in_data.req_type == REQ_POP_BACK) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        REQ_SIZE: begin
          res_rv = {{(32-CW){1'b0}}, count_r};
        end
        REQ_EMPTY: begin
          res_rv = {31'b0, empty};
        end
        default: begin
          res_rv = '0;
        end
      endcase
    end
  end

  // read and write never share a cycle, and a read in the cycle after a
  // write to the same entry sees the new word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= in_data.push_value;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mem_r <= res_mem;
      s1_rv_r  <= res_rv;
      s1_st_r  <= res_st;
    end
    if (s1_adv) begin
      out_data_r.read_value <= s1_mem_r ? rd_q_r : s1_rv_r;
      out_data_r.status     <= s1_st_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `DQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `DQ_ASSERT_NEXT(a_push_counts, clk, rst_n, push_ok, count_r == $past(count_r) + CW'(1))
  `DQ_ASSERT_NEXT(a_read_lands, clk, rst_n, rd_en, s1_v_r && s1_mem_r)
  `DQ_ASSERT_NOW(a_no_rw_clash, clk, rst_n, wr_en, !rd_en)

endmodule

FILE: tb/double_ended_queue_core_test.sv
// self-checking bench for double_ended_queue_core: random push, pop, peek and
// occupancy requests checked against a ring-buffer deque kept in the bench
// depends on dq_pkg and the double_ended_queue_core rtl
`timescale 1ns / 1ps

module double_ended_queue_core_test;
  import dq_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_LIMIT  = 50;
  localparam int TAIL_CYCLES  = 12;
  localparam int DRAIN_CYCLES = 5000;

  // deque model plus the queue of results still owed by the block
  class deque_scoreboard;
    logic [31:0]   slots [DEPTH];
    logic [AW-1:0] head;
    logic [CW-1:0] occupancy;
    dq_out_t       owed_q [$];
    int            errors;
    int            checked;
    int            refused_pushes;
    int            empty_reads;
    int            peak;

    function new();
      head      = '0;
      occupancy = '0;
    endfunction

    function logic [AW-1:0] slot_at(int offset);
      return AW'((int'(head) + offset) % DEPTH);
    endfunction

    function void note_request(dq_in_t w);
      dq_out_t r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (w.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (occupancy == CW'(DEPTH)) begin
            r.status = ST_FULL;
            refused_pushes++;
          end else if (w.req_type == REQ_PUSH_FRONT) begin
            head = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
            slots[head] = w.push_value;
            occupancy++;
          end else begin
            slots[slot_at(int'(occupancy))] = w.push_value;
            occupancy++;
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (occupancy == '0) begin
            r.read_value = '1;
            r.status     = ST_EMPTY;
            empty_reads++;
          end else if (w.req_type == REQ_POP_FRONT || w.req_type == REQ_PEEK_FRONT) begin
            r.read_value = slots[head];
            if (w.req_type == REQ_POP_FRONT) begin
              head = slot_at(1);
              occupancy--;
            end
          end else begin
            r.read_value = slots[slot_at(int'(occupancy) - 1)];
            if (w.req_type == REQ_POP_BACK) occupancy--;
          end
        end
        REQ_SIZE: begin
          r.read_value = 32'(occupancy);
        end
        default: begin
          r.read_value = (occupancy == '0) ? 32'd1 : 32'd0;
        end
      endcase
      if (int'(occupancy) > peak) peak = int'(occupancy);
      owed_q.insert(owed_q.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      // keep the log short on a badly broken build, but count everything
      if (errors < PRINT_LIMIT) begin
        $display("error at %0t: %s, got %0h, want %0h", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(dq_out_t got);
      dq_out_t want;
      if (owed_q.size() == 0) begin
        report("result with nothing outstanding", got.read_value, '0);
      end else begin
        want = owed_q[0];
        owed_q.delete(0);
        checked++;
        if (got.read_value !== want.read_value) begin
          report("read_value", got.read_value, want.read_value);
        end
        if (got.status !== want.status) begin
          report("status", 32'(got.status), 32'(want.status));
        end
      end
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  dq_in_t          in_data;
  logic            out_valid;
  logic            out_ready;
  dq_out_t         out_data;

  deque_scoreboard sb = new();
  bit              quiet;
  bit              hold_request;
  bit              holding;
  int              n_sent;

  double_ended_queue_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("double_ended_queue_core: mismatch");
    $finish;
  end

  task automatic send_word(input dq_in_t w);
    if (!quiet && !holding && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_request(w);
    n_sent++;
  endtask

  task automatic send_kind(input req_kind_t kind, input logic [31:0] value);
    dq_in_t w;
    w.req_type   = kind;
    w.push_value = value;
    send_word(w);
  endtask

  // push_pct sets the share of pushes, the rest is spread over the other six kinds
  function automatic dq_in_t pick_word(int push_pct);
    dq_in_t w;
    w.push_value = $urandom;
    if ($urandom_range(0, 99) < push_pct) begin
      w.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else begin
      w.req_type = req_kind_t'($urandom_range(REQ_POP_FRONT, REQ_PEEK_BACK));
    end
    return w;
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        out_ready   <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        holding = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int n;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store first, then the field extremes and every request kind
    send_kind(REQ_POP_FRONT, $urandom);
    send_kind(REQ_POP_BACK, $urandom);
    send_kind(REQ_PEEK_FRONT, $urandom);
    send_kind(REQ_PEEK_BACK, $urandom);
    send_kind(REQ_SIZE, $urandom);
    send_kind(REQ_EMPTY, $urandom);
    send_kind(REQ_PUSH_FRONT, 32'h8000_0000);
    send_kind(REQ_PUSH_BACK, 32'h7fff_ffff);
    send_kind(REQ_PUSH_FRONT, 32'hffff_ffff);
    send_kind(REQ_PUSH_BACK, 32'h0000_0000);
    send_kind(REQ_PUSH_FRONT, 32'h5555_5555);
    send_kind(REQ_PUSH_BACK, 32'haaaa_aaaa);
    send_kind(REQ_SIZE, $urandom);
    send_kind(REQ_EMPTY, $urandom);
    send_kind(REQ_PEEK_FRONT, $urandom);
    send_kind(REQ_PEEK_BACK, $urandom);
    repeat (3) begin
      send_kind(REQ_POP_FRONT, $urandom);
      send_kind(REQ_POP_BACK, $urandom);
    end
    send_kind(REQ_EMPTY, $urandom);
    send_kind(REQ_PEEK_BACK, $urandom);

    // balanced traffic, hovers near empty and wraps the head both ways
    repeat (200) send_word(pick_word(50));

    // fill to the top, with the long output hold early on
    n = 0;
    while (sb.occupancy != CW'(DEPTH)) begin
      if (n == 40) hold_request = 1'b1;
      send_word(pick_word(95));
      n++;
    end

    // push-heavy traffic against a full store
    repeat (24) send_word(pick_word(70));

    // back-to-back drain with both sides always ready
    quiet = 1'b1;
    repeat (200) send_word(pick_word(10));
    in_valid <= 1'b0;

    for (int c = 0; c < DRAIN_CYCLES && sb.owed_q.size() != 0; c++) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      sb.report("results never arrived", sb.owed_q.size(), '0);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests, %0d results checked, peak occupancy %0d of %0d",
             n_sent, sb.checked, sb.peak, DEPTH);
    $display("%0d pushes refused when full, %0d pops or peeks on an empty store",
             sb.refused_pushes, sb.empty_reads);
    if (sb.errors == 0) begin
      $display("double_ended_queue_core: match");
    end else begin
      $display("double_ended_queue_core: mismatch");
    end
    $finish;
  end

endmodule
